@@ rtl/core/sle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types for the sequential list engine
// Request and result beats, operation and status codes, controller commands.
// ----------------------------------------------------------------------------
package sle_pkg;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_DELETE     = 3'd1,
        OP_REMOVE_EQ  = 3'd2,
        OP_DEDUP      = 3'd3,
        OP_DEDUP_SORT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [5:0]         position;
        logic signed [31:0] elem_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [5:0]         new_length;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch request, reset indexes
        logic rd_issue;  // read store at rd index (data next cycle)
        logic rd_j;      // read store at j index instead
        logic step;      // evaluate captured read data for current op
        logic finish;    // end of op; insert writes its new word at pos
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic done;      // current op has no more work
        logic scan;      // unsorted dedup is scanning the kept prefix
    } dp_sts_t;

endpackage

@@ rtl/core/sle_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_datapath: list store, length and walk indexes
// Executes one read-evaluate step per command pair while the op has store work.
// ----------------------------------------------------------------------------
module sle_datapath #(
    parameter int CAPACITY = 32,
    parameter int IW       = 5,
    parameter int LW       = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sle_pkg::req_t    req,
    input  sle_pkg::dp_cmd_t cmd,
    output sle_pkg::dp_sts_t sts,
    output sle_pkg::rsp_t    rsp
);

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] rd_reg, rd_next;   // read cursor
    logic [LW-1:0] wr_reg, wr_next;   // write cursor / kept count
    logic [LW-1:0] j_reg, j_next;     // inner scan for dedup
    logic [31:0]   cur_reg, cur_next; // word under test (dedup) / last kept
    logic          phase_reg, phase_next; // dedup: 0 fetch cur, 1 scanning
    logic [2:0]    op_reg;
    logic [LW-1:0] pos_reg;
    logic [31:0]   val_reg;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   rem_reg, rem_next;
    logic          done_reg, done_next;
    logic          we;
    logic [LW-1:0] waddr;
    logic [31:0]   wdata;
    logic [LW-1:0] raddr;
    logic [LW-1:0] req_pos;

    assign raddr   = cmd.rd_j ? j_reg : rd_reg;
    assign req_pos = LW'(req.position);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr[IW-1:0]] <= wdata;
        if (cmd.rd_issue)
            rdata_reg <= mem[raddr[IW-1:0]];
    end

    always_comb
    begin
        len_next   = len_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        phase_next = phase_reg;
        st_next    = st_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;
        we         = 1'b0;
        waddr      = wr_reg;
        wdata      = rdata_reg;
        if (cmd.load)
        begin
            st_next    = sle_pkg::ST_OK;
            rem_next   = '0;
            phase_next = 1'b0;
            j_next     = '0;
            done_next  = 1'b0;
            case (req.req_type)
                sle_pkg::OP_INSERT:
                begin
                    // walk from top down, wr is destination
                    wr_next = len_reg;
                    rd_next = len_reg - LW'(1);
                    if (len_reg >= LW'(CAPACITY))
                    begin
                        st_next   = sle_pkg::ST_FULL;
                        done_next = 1'b1;
                    end
                    else if (req_pos > len_reg)
                    begin
                        st_next   = sle_pkg::ST_BAD_INDEX;
                        done_next = 1'b1;
                    end
                    else if (req_pos == len_reg)
                    begin
                        we        = 1'b1;
                        waddr     = len_reg;
                        wdata     = req.elem_value;
                        len_next  = len_reg + LW'(1);
                        done_next = 1'b1;
                    end
                end
                sle_pkg::OP_DELETE:
                begin
                    rd_next = req_pos;
                    wr_next = req_pos;
                    if (req_pos >= len_reg)
                    begin
                        st_next   = sle_pkg::ST_BAD_INDEX;
                        done_next = 1'b1;
                    end
                end
                sle_pkg::OP_REMOVE_EQ:
                begin
                    rd_next   = '0;
                    wr_next   = '0;
                    done_next = (len_reg == '0);
                end
                sle_pkg::OP_DEDUP:
                begin
                    rd_next   = LW'(1);
                    wr_next   = LW'(1);
                    done_next = (len_reg <= LW'(1));
                end
                sle_pkg::OP_DEDUP_SORT:
                begin
                    // fetch entry 0 first as the last kept word
                    rd_next   = '0;
                    wr_next   = LW'(1);
                    done_next = (len_reg <= LW'(1));
                end
                default:
                    done_next = 1'b1;
            endcase
        end
        else if (cmd.step)
        begin
            case (op_reg)
                sle_pkg::OP_INSERT:
                begin
                    we      = 1'b1;
                    waddr   = wr_reg;
                    wdata   = rdata_reg;
                    wr_next = wr_reg - LW'(1);
                    rd_next = rd_reg - LW'(1);
                    if (rd_reg == pos_reg)
                    begin
                        // moved the entry at pos; place new word after
                        done_next = 1'b1;
                        len_next  = len_reg + LW'(1);
                        phase_next = 1'b1;
                    end
                end
                sle_pkg::OP_DELETE:
                begin
                    if (rd_reg == pos_reg && !phase_reg)
                    begin
                        rem_next   = rdata_reg;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        we      = 1'b1;
                        waddr   = wr_reg;
                        wr_next = wr_reg + LW'(1);
                    end
                    rd_next = rd_reg + LW'(1);
                    if (rd_reg + LW'(1) >= len_reg)
                    begin
                        done_next = 1'b1;
                        len_next  = len_reg - LW'(1);
                    end
                end
                sle_pkg::OP_REMOVE_EQ:
                begin
                    if (rdata_reg != val_reg)
                    begin
                        we      = 1'b1;
                        waddr   = wr_reg;
                        wr_next = wr_reg + LW'(1);
                    end
                    rd_next = rd_reg + LW'(1);
                    if (rd_reg + LW'(1) >= len_reg)
                    begin
                        done_next = 1'b1;
                        len_next  = (rdata_reg != val_reg) ? wr_reg + LW'(1) : wr_reg;
                    end
                end
                sle_pkg::OP_DEDUP_SORT:
                begin
                    if (!phase_reg)
                    begin
                        // first step: fetched entry 0 as last kept
                        cur_next   = rdata_reg;
                        phase_next = 1'b1;
                        rd_next    = rd_reg + LW'(1);
                    end
                    else
                    begin
                        if (rdata_reg != cur_reg)
                        begin
                            we       = 1'b1;
                            waddr    = wr_reg;
                            wr_next  = wr_reg + LW'(1);
                            cur_next = rdata_reg;
                        end
                        rd_next = rd_reg + LW'(1);
                        if (rd_reg + LW'(1) >= len_reg)
                        begin
                            done_next = 1'b1;
                            len_next  = (rdata_reg != cur_reg) ? wr_reg + LW'(1)
                                                               : wr_reg;
                        end
                    end
                end
                sle_pkg::OP_DEDUP:
                begin
                    if (!phase_reg)
                    begin
                        // fetched candidate at rd; start scan of kept prefix
                        cur_next   = rdata_reg;
                        phase_next = 1'b1;
                        j_next     = '0;
                    end
                    else
                    begin
                        if (rdata_reg == cur_reg || j_reg + LW'(1) >= wr_reg)
                        begin
                            if (rdata_reg != cur_reg)
                            begin
                                we      = 1'b1;
                                waddr   = wr_reg;
                                wdata   = cur_reg;
                                wr_next = wr_reg + LW'(1);
                            end
                            phase_next = 1'b0;
                            rd_next    = rd_reg + LW'(1);
                            if (rd_reg + LW'(1) >= len_reg)
                            begin
                                done_next = 1'b1;
                                len_next  = (rdata_reg != cur_reg) ? wr_reg + LW'(1)
                                                                   : wr_reg;
                            end
                        end
                        else
                            j_next = j_reg + LW'(1);
                    end
                end
                default:
                    done_next = 1'b1;
            endcase
        end
        else if (cmd.finish && op_reg == sle_pkg::OP_INSERT && phase_reg)
        begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg  <= rd_next;
        wr_reg  <= wr_next;
        j_reg   <= j_next;
        cur_reg <= cur_next;
        st_reg  <= st_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            op_reg  <= req.req_type;
            pos_reg <= req_pos;
            val_reg <= req.elem_value;
        end
    end

    assign sts.done          = done_reg;
    assign sts.scan          = (op_reg == sle_pkg::OP_DEDUP) && phase_reg;
    assign rsp.status        = st_reg;
    assign rsp.removed_value = rem_reg;
    assign rsp.new_length    = len_reg[5:0];

endmodule

@@ rtl/core/sle_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl: sequencing controller
// Accepts a request beat, alternates read and evaluate steps, delivers result.
// ----------------------------------------------------------------------------
module sle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  sle_pkg::dp_sts_t sts,
    output sle_pkg::dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.done)
                    state_next = S_FIN;
                else
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_j     = sts.scan;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.step   = 1'b1;
                state_next = S_READ;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/sequential_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine: packed list of signed words with edit operations
// One request at a time; each store step is a read state then an evaluate
// state, and the next request is taken the cycle after the result leaves.
// Store steps: insert/delete length - position; remove and sorted dedup length.
// Unsorted dedup adds an inner scan of the kept prefix for each candidate.
// Errors, append and unused codes take no store steps. Reset clears length and control.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  sle_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output sle_pkg::rsp_t out_data
);

    // Index width covers the store; length width must hold CAPACITY itself
    // and no less than the 6-bit fields of the beat.
    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int LW = (IW + 1 > 6) ? IW + 1 : 6;

    sle_pkg::dp_cmd_t cmd;
    sle_pkg::dp_sts_t sts;

    // The datapath reports when unsorted dedup is in its inner scan, so the
    // controller reads at the scan index rather than the read cursor.
    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .LW       (LW)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (out_data)
    );

    // A result beat never shows while a request beat is being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("result and request overlap");

    // Length never exceeds the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.new_length <= CAPACITY))
        else $error("length beyond capacity");

    // A taken request is followed by work, not by another take.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while busy");

endmodule
